FILE: sv/dqe_pkg.sv
// Shared types and codes for the double-ended queue engine.
package dqe_pkg;

    localparam int WORD_W   = 64;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_SHIFT_OUT,
        CELL_WRITE_AT
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_REPORT
    } state_t;

    typedef struct packed {
        cell_op_t            op;
        logic [WORD_W-1:0]   word;
    } chain_ctrl_t;

endpackage

FILE: sv/double_ended_queue_engine.sv
// Top level of the double-ended queue engine: command sequencer, two cell chains, result register.
//
// Usage: each request on the s_ channel carries a command in s_tuser and a word in s_tdata.
// Commands push or pop a word at either end, or search and destroy: trim both ends one
// pair per cycle until the back or the front word equals the given word, then remove it.
// Every request yields one result on the m_ channel with the front and back words, the
// number of words held and a status code (ok, overflow, underflow, not found).
// The queue is stored twice, in a chain of cells ordered from the front and in a chain
// ordered from the back, so both ends sit in a fixed cell and every cell takes data only
// from its neighbors or the input word; a chain shifts by one cell per cycle.
// Push, pop and unused codes pass from accept through S_REPORT to the result; search
// first stays in S_SEARCH, trimming one pair per step, until a compare hits or the
// queue is empty.
// One request is in work at a time. The next request is accepted while a finished
// result still waits in the output register; a stalled receiver holds the block only
// once a second result is ready.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result; the
// cell contents are not cleared and are never shown for an empty queue.
module double_ended_queue_engine #(
    parameter int DEPTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // [63:0] word
    input  logic [2:0]    s_tuser,   // [2:0] cmd
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,   // [63:0] front_word, [127:64] back_word,
                                     // [132:128] entries, [135:133] zero
    output logic [1:0]    m_tuser    // [1:0] status
);
    import dqe_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             status_reg, status_next;
    logic [WORD_W-1:0]   key_reg, key_next;

    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_front_reg, out_front_next;
    logic [WORD_W-1:0]   out_back_reg, out_back_next;
    logic [ENTRY_W-1:0]  out_entries_reg, out_entries_next;
    status_t             out_status_reg, out_status_next;

    chain_ctrl_t         front_ctrl, back_ctrl;
    logic [WORD_W-1:0]   front_head, back_head;

    logic                accept;
    logic                out_load;
    logic                empty;
    logic                full;
    logic [CNT_W+ENTRY_W-1:0] count_wide;
    cmd_t                cmd;

    assign accept     = s_tvalid && s_tready;
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign count_wide = {{ENTRY_W{1'b0}}, count_reg};
    assign cmd        = cmd_t'(s_tuser);

    dqe_chain #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_front_chain (
        .aclk   (aclk),
        .ctrl   (front_ctrl),
        .wr_idx (count_reg),
        .head   (front_head)
    );

    dqe_chain #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_back_chain (
        .aclk   (aclk),
        .ctrl   (back_ctrl),
        .wr_idx (count_reg),
        .head   (back_head)
    );

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        status_next      = status_reg;
        key_next         = key_reg;
        front_ctrl.op    = CELL_HOLD;
        front_ctrl.word  = s_tdata;
        back_ctrl.op     = CELL_HOLD;
        back_ctrl.word   = s_tdata;
        s_tready         = 1'b0;
        out_load         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    state_next  = S_REPORT;
                    status_next = STAT_OK;
                    case (cmd)
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                status_next = STAT_OVERFLOW;
                            end else begin
                                front_ctrl.op = CELL_SHIFT_IN;
                                back_ctrl.op  = CELL_WRITE_AT;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                status_next = STAT_OVERFLOW;
                            end else begin
                                front_ctrl.op = CELL_WRITE_AT;
                                back_ctrl.op  = CELL_SHIFT_IN;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                status_next = STAT_UNDERFLOW;
                            end else begin
                                front_ctrl.op = CELL_SHIFT_OUT;
                                count_next    = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                status_next = STAT_UNDERFLOW;
                            end else begin
                                back_ctrl.op = CELL_SHIFT_OUT;
                                count_next   = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_SEARCH: begin
                            key_next   = s_tdata;
                            state_next = S_SEARCH;
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (empty) begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = S_REPORT;
                end else if (back_head == key_reg) begin
                    back_ctrl.op = CELL_SHIFT_OUT;
                    count_next   = count_reg - CNT_W'(1);
                    status_next  = STAT_OK;
                    state_next   = S_REPORT;
                end else if (front_head == key_reg) begin
                    front_ctrl.op = CELL_SHIFT_OUT;
                    count_next    = count_reg - CNT_W'(1);
                    status_next   = STAT_OK;
                    state_next    = S_REPORT;
                end else begin
                    // discard both ends; a single word is both ends at once
                    front_ctrl.op = CELL_SHIFT_OUT;
                    back_ctrl.op  = CELL_SHIFT_OUT;
                    count_next    = (count_reg == CNT_W'(1)) ? '0 : count_reg - CNT_W'(2);
                end
            end
            S_REPORT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next   = out_valid_reg;
        out_front_next   = out_front_reg;
        out_back_next    = out_back_reg;
        out_entries_next = out_entries_reg;
        out_status_next  = out_status_reg;
        if (out_load) begin
            out_valid_next   = 1'b1;
            out_front_next   = empty ? '0 : front_head;
            out_back_next    = empty ? '0 : back_head;
            out_entries_next = count_wide[ENTRY_W-1:0];
            out_status_next  = status_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= STAT_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg         <= key_next;
        out_front_reg   <= out_front_next;
        out_back_reg    <= out_back_next;
        out_entries_reg <= out_entries_next;
        out_status_reg  <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_entries_reg, out_back_reg, out_front_reg};
    assign m_tuser  = out_status_reg;

    // count never passes the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("held count exceeds capacity");

    // a push into a full queue leaves the count alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK))
        |=> (count_reg == $past(count_reg)))
        else $error("push into full queue changed the count");

    // every search step that goes on shrinks the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH && state_next == S_SEARCH)
        |=> (count_reg < $past(count_reg)))
        else $error("search step did not shrink the queue");

    // a result for an empty queue shows zero words
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && empty) |=> (out_front_reg == '0 && out_back_reg == '0))
        else $error("empty queue reported nonzero words");

endmodule

FILE: sv/dqe_cell.sv
// One storage cell of a queue chain: holds a word, takes a neighbor's or the input word.
module dqe_cell (
    input  logic                      aclk,
    input  dqe_pkg::cell_op_t         op,
    input  logic                      hit,
    input  logic [dqe_pkg::WORD_W-1:0] word,
    input  logic [dqe_pkg::WORD_W-1:0] left,
    input  logic [dqe_pkg::WORD_W-1:0] right,
    output logic [dqe_pkg::WORD_W-1:0] q
);
    import dqe_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (op)
            CELL_HOLD:      data_next = data_reg;
            CELL_SHIFT_IN:  data_next = left;
            CELL_SHIFT_OUT: data_next = right;
            CELL_WRITE_AT:  data_next = hit ? word : data_reg;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

FILE: sv/dqe_chain.sv
// Row of cells holding the queue in order from one end; cell zero is that end.
module dqe_chain #(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                       aclk,
    input  dqe_pkg::chain_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]           wr_idx,
    output logic [dqe_pkg::WORD_W-1:0] head
);
    import dqe_pkg::*;

    logic [WORD_W-1:0] q [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic [WORD_W-1:0] left_w;
            logic [WORD_W-1:0] right_w;

            if (i == 0) begin : g_first
                assign left_w = ctrl.word;
            end else begin : g_mid_l
                assign left_w = q[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign right_w = q[i];
            end else begin : g_mid_r
                assign right_w = q[i+1];
            end

            dqe_cell u_cell (
                .aclk  (aclk),
                .op    (ctrl.op),
                .hit   (wr_idx == CNT_W'(i)),
                .word  (ctrl.word),
                .left  (left_w),
                .right (right_w),
                .q     (q[i])
            );
        end
    endgenerate

    assign head = q[0];

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the double-ended queue engine: random stream traffic, deque predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dqe_pkg::*;

    localparam int DQ_DEPTH      = 16;
    localparam logic [2:0] CMD_LAST_CODE = 3'd7;
    localparam int RANDOM_PER_PHASE = 670;
    localparam int HOLD_AT_REQ   = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTED   = 30;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] word;
    } dq_req_t;

    typedef struct packed {
        logic [63:0] front;
        logic [63:0] back;
        logic [4:0]  entries;
        status_t     status;
    } deque_view_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [63:0]   s_tdata  = '0;
    logic [2:0]    s_tuser  = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [135:0]  m_tdata;
    logic [1:0]    m_tuser;

    double_ended_queue_engine #(.DEPTH(DQ_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted deque contents
    logic [63:0] dq_ring [DQ_DEPTH];
    int          dq_head = 0;
    int          dq_tail = 0;
    int          dq_held = 0;

    dq_req_t     pending_reqs [$];
    deque_view_t expected_views [$];
    logic [63:0] word_pool [8];

    int snd_idle_pct = 9;
    int rcv_idle_pct = 50;
    int accepted_reqs = 0;
    int checked_results = 0;
    int error_count = 0;
    int n_push = 0, n_pop = 0, n_search = 0, n_unused = 0;
    int n_ok = 0, n_overflow = 0, n_underflow = 0, n_not_found = 0;

    int   hold_left = 0;
    logic hold_done = 1'b0;

    function automatic int ring_next(input int i);
        return (i + 1) % DQ_DEPTH;
    endfunction

    function automatic int ring_prev(input int i);
        return (i + DQ_DEPTH - 1) % DQ_DEPTH;
    endfunction

    function automatic void take_front();
        if (dq_held == 0) return;
        dq_held--;
        if (dq_held != 0) dq_head = ring_next(dq_head);
        else dq_tail = dq_head;
    endfunction

    function automatic void take_back();
        if (dq_held == 0) return;
        dq_held--;
        if (dq_held != 0) dq_tail = ring_prev(dq_tail);
        else dq_tail = dq_head;
    endfunction

    // Apply one request to the predicted deque and return the view it leaves.
    function automatic deque_view_t deque_apply(input logic [2:0] cmd, input logic [63:0] w);
        deque_view_t v;
        logic        found;
        v.status = STAT_OK;
        found = 1'b0;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (dq_held >= DQ_DEPTH) begin
                    v.status = STAT_OVERFLOW;
                end else begin
                    if (dq_held == 0) dq_tail = dq_head;
                    else if (cmd == CMD_PUSH_FRONT) dq_head = ring_prev(dq_head);
                    else dq_tail = ring_next(dq_tail);
                    dq_ring[(cmd == CMD_PUSH_FRONT) ? dq_head : dq_tail] = w;
                    dq_held++;
                end
            end
            CMD_POP_FRONT: begin
                if (dq_held == 0) v.status = STAT_UNDERFLOW;
                else take_front();
            end
            CMD_POP_BACK: begin
                if (dq_held == 0) v.status = STAT_UNDERFLOW;
                else take_back();
            end
            CMD_SEARCH: begin
                // trim both ends until the back, then the front, matches
                while (dq_held != 0 && !found) begin
                    if (dq_ring[dq_tail] == w) begin
                        take_back();
                        found = 1'b1;
                    end else if (dq_ring[dq_head] == w) begin
                        take_front();
                        found = 1'b1;
                    end else begin
                        take_back();
                        take_front();
                    end
                end
                if (!found) v.status = STAT_NOT_FOUND;
            end
            default: ;
        endcase
        v.front   = (dq_held != 0) ? dq_ring[dq_head] : '0;
        v.back    = (dq_held != 0) ? dq_ring[dq_tail] : '0;
        v.entries = 5'(dq_held);
        return v;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_PRINTED)
            $display("[%0t] result %0d: %s mismatch, got %h, expected %h",
                     $realtime, checked_results, field, got, want);
        error_count++;
    endtask

    // Driver: predict on accept, then offer the next request or idle.
    always @(posedge aclk) begin
        deque_view_t v;
        dq_req_t     r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                v = deque_apply(s_tuser, s_tdata);
                expected_views.push_back(v);
                accepted_reqs++;
                case (s_tuser)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: n_push++;
                    CMD_POP_FRONT, CMD_POP_BACK:   n_pop++;
                    CMD_SEARCH:                    n_search++;
                    default:                       n_unused++;
                endcase
                case (v.status)
                    STAT_OK:        n_ok++;
                    STAT_OVERFLOW:  n_overflow++;
                    STAT_UNDERFLOW: n_underflow++;
                    default:        n_not_found++;
                endcase
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= r.cmd;
                    s_tdata  <= r.word;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && accepted_reqs >= HOLD_AT_REQ) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge aclk) begin
        deque_view_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_views.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], '0);
            end else begin
                e = expected_views.pop_front();
                if (m_tdata[63:0] !== e.front)
                    report_mismatch("front_word", m_tdata[63:0], e.front);
                if (m_tdata[127:64] !== e.back)
                    report_mismatch("back_word", m_tdata[127:64], e.back);
                if (m_tdata[132:128] !== e.entries)
                    report_mismatch("entries", 64'(m_tdata[132:128]), 64'(e.entries));
                if (m_tdata[135:133] !== 3'b000)
                    report_mismatch("tdata pad", 64'(m_tdata[135:133]), '0);
                if (m_tuser !== e.status)
                    report_mismatch("status", 64'(m_tuser), 64'(e.status));
            end
            checked_results++;
        end
    end

    task automatic add_req(input logic [2:0] cmd, input logic [63:0] w);
        dq_req_t r;
        r.cmd  = cmd;
        r.word = w;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [63:0] tag_word(input int i);
        return {32'hA5A5_0000 + 32'(i), 32'h0F0F_0000 + 32'(i)};
    endfunction

    // Random requests in segments that lean toward filling or draining the deque, or are balanced.
    task automatic add_random(input int n);
        int          push_pct;
        int          roll;
        logic [2:0]  cmd;
        logic [63:0] w;
        push_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) push_pct = 20 + 30 * $urandom_range(2);
            roll = $urandom_range(99);
            if (roll < 3)
                cmd = 3'($urandom_range(CMD_LAST_CODE, CMD_SEARCH + 1));
            else if (roll < 15)
                cmd = CMD_SEARCH;
            else if ($urandom_range(99) < push_pct)
                cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else
                cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
            // draw mostly from a small pool so searches hit
            if ($urandom_range(99) < 70) w = word_pool[$urandom_range(7)];
            else w = {$urandom, $urandom};
            add_req(cmd, w);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_views.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        word_pool[0] = '0;
        word_pool[1] = '1;
        for (int i = 2; i < 8; i++) word_pool[i] = {$urandom, $urandom};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty deque: search, pops, an unused code
        add_req(CMD_SEARCH, '0);
        add_req(CMD_POP_FRONT, '0);
        add_req(CMD_POP_BACK, '1);
        add_req(CMD_LAST_CODE, '1);
        // Pushes into an empty deque from either end
        add_req(CMD_PUSH_FRONT, '1);
        add_req(CMD_POP_FRONT, '0);
        add_req(CMD_PUSH_BACK, '0);
        // Fill up, then overflow at both ends
        for (int i = 0; i < 15; i++)
            add_req((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, tag_word(i));
        add_req(CMD_PUSH_BACK, '1);
        add_req(CMD_PUSH_FRONT, '1);
        // Match at the front, match after trimming, then no match
        add_req(CMD_SEARCH, tag_word(14));
        add_req(CMD_SEARCH, tag_word(6));
        add_req(CMD_SEARCH, 64'd1);

        add_random(RANDOM_PER_PHASE);
        wait_drained();

        snd_idle_pct = 50;
        rcv_idle_pct = 9;
        add_random(RANDOM_PER_PHASE);
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        add_random(RANDOM_PER_PHASE);
        wait_drained();

        repeat (40) @(posedge aclk);

        $display("Checked %0d results for %0d requests: %0d push, %0d pop, %0d search, %0d unused",
                 checked_results, accepted_reqs, n_push, n_pop, n_search, n_unused);
        $display("Status mix: %0d ok, %0d overflow, %0d underflow, %0d not found; %0d errors",
                 n_ok, n_overflow, n_underflow, n_not_found, error_count);
        if (error_count == 0 && expected_views.size() == 0) begin
            $display("** double_ended_queue_engine: PASSED **");
        end else begin
            $display("** double_ended_queue_engine: FAILED **");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d results still expected", expected_views.size());
        $display("** double_ended_queue_engine: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
sv/dqe_pkg.sv
sv/dqe_cell.sv
sv/dqe_chain.sv
sv/double_ended_queue_engine.sv
tb/tb_top.sv
